// ===== rtl/core/image_format_sniffer_defines.svh =====
// Assertion macros used by the image format sniffer top level.
`ifndef IMAGE_FORMAT_SNIFFER_DEFINES_SVH
`define IMAGE_FORMAT_SNIFFER_DEFINES_SVH

// Antecedent true implies consequent true in the same cycle.
`define IFS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("image_format_sniffer: check failed");

// Antecedent true implies consequent true in the next cycle.
`define IFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("image_format_sniffer: check failed");

`endif

// ===== rtl/core/ifs_pkg.sv =====
// Types and constants of the image format sniffer.
package ifs_pkg;

    localparam int WIN_BYTES  = 30;   // header bytes the decoder looks at
    localparam int PROBE_CMP  = 9;    // probe characters the decoder looks at
    localparam int CNT_W      = 7;    // byte count as seen by the decoder
    localparam int PCNT_W     = 6;    // probe count as seen by the decoder
    localparam int DIM_W      = 31;

    typedef logic [7:0] byte_t;
    typedef logic [DIM_W-1:0] dim_t;
    typedef logic [WIN_BYTES-1:0][7:0] head_win_t;
    typedef logic [PROBE_CMP-1:0][7:0] probe_win_t;

    typedef enum logic [3:0] {
        FMT_UNKNOWN = 4'd0,
        FMT_JPEG    = 4'd1,
        FMT_PNG     = 4'd2,
        FMT_GIF     = 4'd3,
        FMT_BMP     = 4'd4,
        FMT_TIFF    = 4'd5,
        FMT_WEBP    = 4'd6,
        FMT_AVIF    = 4'd7,
        FMT_HEIF    = 4'd8,
        FMT_VIDEO   = 4'd9,
        FMT_HTML    = 4'd10
    } fmt_t;

    typedef enum logic [1:0] {
        EDGE_OK          = 2'd0,
        EDGE_EMPTY       = 2'd1,
        EDGE_TOO_LARGE   = 2'd2,
        EDGE_NOT_CHECKED = 2'd3
    } edge_t;

    typedef enum logic [1:0] {
        PH_MARK    = 2'd0,
        PH_SKIP    = 2'd1,
        PH_COLLECT = 2'd2,
        PH_FULL    = 2'd3
    } phase_t;

    localparam dim_t DIM_MAX = {DIM_W{1'b1}};

    // Snapshot of the stores after the current word, handed to the decoder.
    typedef struct packed {
        head_win_t         head;
        logic [CNT_W-1:0]  count;
        probe_win_t        probe;
        logic [PCNT_W-1:0] probe_count;
    } snap_t;

    typedef struct packed {
        fmt_t  kind;
        dim_t  width;
        dim_t  height;
        logic  known;
        edge_t status;
    } result_t;

endpackage

// ===== rtl/core/image_format_sniffer.sv =====
// Top level of the image format sniffer: input stage, result register and config port.
//
// Channel   Direction  Width  Contents
// s_*       in         8+1    one file byte per word, tlast on the final byte
// m_*       out        72     one result word per file
// APB       in/out     32     register max_edge at byte address 0
//
// An input word is registered; when the input stage moves on, its byte goes into
// the header store and the probe, and on a last byte the decoder reads the updated
// stores so the result register loads at that same edge. One word per cycle is taken
// unless a staged last byte is stalled, and the result turns valid as it loads.
// Reset clears the counts, the probe phase and the valids, not the byte stores.
// A waiting result holds back the input only once the next last byte is staged.
`include "image_format_sniffer_defines.svh"
module image_format_sniffer
    import ifs_pkg::*;
#(
    parameter int HEAD_BYTES  = 32,
    parameter int PROBE_CHARS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] data_byte
    input  logic        s_tlast,     // last_byte
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata      // [3:0] format_kind, [34:4] image_width,
                                     // [65:35] image_height, [66] dims_known,
                                     // [68:67] edge_status, [71:69] zero
);

    localparam logic ADDR_MAX_EDGE = 1'b0;

    dim_t    max_edge_reg;
    logic    in_valid_reg;
    byte_t   in_data_reg;
    logic    in_last_reg;
    logic    out_valid_reg;
    result_t out_reg;
    logic    fire;
    snap_t   snap;
    result_t result;

    // The input stage moves on every cycle unless it holds a last byte whose
    // result would land on a result word that is still waiting.
    assign fire     = in_valid_reg && !(in_last_reg && out_valid_reg && !m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign pready   = 1'b1;
    assign prdata   = {1'b0, max_edge_reg};
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.status, out_reg.known, out_reg.height,
                       out_reg.width, out_reg.kind};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_edge_reg <= DIM_W'(16384);
        end
        else if (psel && penable && pwrite && paddr[2] == ADDR_MAX_EDGE)
        begin
            max_edge_reg <= pwdata[30:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (fire && in_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (fire && in_last_reg)
        begin
            out_reg <= result;
        end
    end

    ifs_capture #(
        .HEAD_BYTES  (HEAD_BYTES),
        .PROBE_CHARS (PROBE_CHARS)
    ) u_capture (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (fire),
        .data_byte (in_data_reg),
        .last_byte (in_last_reg),
        .snap      (snap)
    );

    ifs_decode u_decode (
        .snap     (snap),
        .max_edge (max_edge_reg),
        .result   (result)
    );

    `IFS_ASSERT_SAME(a_stall_blocks_input, clk, rst_n,
        in_valid_reg && in_last_reg && out_valid_reg && !m_tready, !s_tready)
    `IFS_ASSERT_SAME(a_unknown_dims_zero, clk, rst_n,
        m_tvalid && !out_reg.known,
        out_reg.width == '0 && out_reg.height == '0 && out_reg.status == EDGE_NOT_CHECKED)
    `IFS_ASSERT_NEXT(a_last_gives_result, clk, rst_n, fire && in_last_reg, m_tvalid)

endmodule

// ===== rtl/core/ifs_capture.sv =====
// Header byte store and HTML probe of the image format sniffer.
module ifs_capture
    import ifs_pkg::*;
#(
    parameter int HEAD_BYTES  = 32,
    parameter int PROBE_CHARS = 16
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  step,
    input  byte_t data_byte,
    input  logic  last_byte,
    output snap_t snap
);

    localparam int HW = $clog2(HEAD_BYTES);
    localparam int HC = $clog2(HEAD_BYTES + 1);
    localparam int PW = $clog2(PROBE_CHARS);
    localparam int PC = $clog2(PROBE_CHARS + 1);

    typedef struct packed {
        phase_t                      phase;
        logic [PC-1:0]               count;
        logic [PROBE_CHARS-1:0][7:0] store;
    } probe_t;

    logic [HEAD_BYTES-1:0][7:0]  head_reg, head_next;
    logic [HC-1:0]               count_reg, count_next;
    phase_t                      phase_reg;
    logic [PC-1:0]               pcount_reg;
    logic [PROBE_CHARS-1:0][7:0] pstore_reg;
    probe_t                      probe_cur, probe_next;

    function automatic logic is_ws(byte_t c);
        is_ws = (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic probe_t feed(probe_t p, byte_t c);
        probe_t q;
        q = p;
        if (q.phase == PH_SKIP && !is_ws(c))
        begin
            q.phase = PH_COLLECT;
        end
        if (q.phase == PH_COLLECT)
        begin
            if (q.count < PC'(PROBE_CHARS))
            begin
                q.store[q.count[PW-1:0]] = ((c >= 8'h41) && (c <= 8'h5A)) ? c + 8'd32 : c;
                q.count = q.count + 1'b1;
            end
            if (q.count >= PC'(PROBE_CHARS))
            begin
                q.phase = PH_FULL;
            end
        end
        feed = q;
    endfunction

    assign probe_cur = {phase_reg, pcount_reg, pstore_reg};

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        probe_next = probe_cur;
        if (count_reg < HC'(HEAD_BYTES))
        begin
            head_next[count_reg[HW-1:0]] = data_byte;
            count_next = count_reg + 1'b1;
        end
        if (probe_cur.phase == PH_MARK)
        begin
            if (count_reg >= HC'(2))
            begin
                probe_next.phase = PH_SKIP;
                // A UTF-8 byte order mark is dropped, otherwise its three bytes feed the probe.
                if (!(head_next[0] == 8'hEF && head_next[1] == 8'hBB && head_next[2] == 8'hBF))
                begin
                    probe_next = feed(probe_next, head_next[0]);
                    probe_next = feed(probe_next, head_next[1]);
                    probe_next = feed(probe_next, head_next[2]);
                end
            end
        end
        else
        begin
            probe_next = feed(probe_cur, data_byte);
        end
    end

    always_comb
    begin
        for (int i = 0; i < WIN_BYTES; i++)
        begin
            snap.head[i] = head_next[i];
        end
        for (int i = 0; i < PROBE_CMP; i++)
        begin
            snap.probe[i] = probe_next.store[i];
        end
        snap.count       = CNT_W'(count_next);
        snap.probe_count = PCNT_W'(probe_next.count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            phase_reg  <= PH_MARK;
            pcount_reg <= '0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                count_reg  <= '0;
                phase_reg  <= PH_MARK;
                pcount_reg <= '0;
            end
            else
            begin
                count_reg  <= count_next;
                phase_reg  <= probe_next.phase;
                pcount_reg <= probe_next.count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            head_reg   <= head_next;
            pstore_reg <= probe_next.store;
        end
    end

endmodule

// ===== rtl/core/ifs_decode.sv =====
// Signature match, header dimension extraction and edge check.
module ifs_decode
    import ifs_pkg::*;
(
    input  snap_t   snap,
    input  dim_t    max_edge,
    output result_t result
);

    head_win_t        h;
    logic [CNT_W-1:0] n;
    fmt_t             kind;
    logic             known;
    logic [31:0]      w32, h32, v;
    dim_t             wd, hd;

    function automatic logic [31:0] be32(head_win_t b, int p);
        be32 = {b[p], b[p+1], b[p+2], b[p+3]};
    endfunction

    function automatic logic [31:0] le32(head_win_t b, int p);
        le32 = {b[p+3], b[p+2], b[p+1], b[p]};
    endfunction

    function automatic logic is4(head_win_t b, int p, logic [31:0] s);
        is4 = {b[p], b[p+1], b[p+2], b[p+3]} == s;
    endfunction

    function automatic dim_t clamp(logic [31:0] x);
        clamp = x[31] ? DIM_MAX : x[30:0];
    endfunction

    logic has4, has12;
    logic html;

    always_comb
    begin
        h     = snap.head;
        n     = snap.count;
        has4  = n >= CNT_W'(4);
        has12 = n >= CNT_W'(12);
        html  = ((snap.probe_count >= PCNT_W'(9)) &&
                 ({snap.probe[0], snap.probe[1], snap.probe[2], snap.probe[3], snap.probe[4],
                   snap.probe[5], snap.probe[6], snap.probe[7], snap.probe[8]}
                  == "<!doctype")) ||
                ((snap.probe_count >= PCNT_W'(5)) &&
                 (({snap.probe[0], snap.probe[1], snap.probe[2], snap.probe[3],
                    snap.probe[4]} == "<html") ||
                  ({snap.probe[0], snap.probe[1], snap.probe[2], snap.probe[3],
                    snap.probe[4]} == "<?xml") ||
                  ({snap.probe[0], snap.probe[1], snap.probe[2], snap.probe[3],
                    snap.probe[4]} == "<head")));

        if (!has4)
            kind = FMT_UNKNOWN;
        else if ({h[0], h[1], h[2]} == 24'hFFD8FF)
            kind = FMT_JPEG;
        else if (n >= CNT_W'(8) && {be32(h, 0), be32(h, 4)} == 64'h89504E470D0A1A0A)
            kind = FMT_PNG;
        else if (n >= CNT_W'(6) && ({h[0], h[1], h[2], h[3], h[4], h[5]} == "GIF87a" ||
                                    {h[0], h[1], h[2], h[3], h[4], h[5]} == "GIF89a"))
            kind = FMT_GIF;
        else if ({h[0], h[1]} == "BM" && n > CNT_W'(14))
            kind = FMT_BMP;
        else if (is4(h, 0, 32'h49492A00) || is4(h, 0, 32'h4D4D002A))
            kind = FMT_TIFF;
        else if (is4(h, 0, "RIFF") && has12 && is4(h, 8, "WEBP"))
            kind = FMT_WEBP;
        else if (is4(h, 0, "RIFF") && has12 && is4(h, 8, "AVI "))
            kind = FMT_VIDEO;
        else if (is4(h, 0, 32'h1A45DFA3) || {h[0], h[1], h[2]} == "FLV" ||
                 is4(h, 0, 32'h000001BA) || is4(h, 0, "OggS") || is4(h, 0, 32'h3026B275))
            kind = FMT_VIDEO;
        else if (has12 && is4(h, 4, "ftyp"))
        begin
            if (is4(h, 8, "avif") || is4(h, 8, "avis"))
                kind = FMT_AVIF;
            else if (is4(h, 8, "heic") || is4(h, 8, "heix") || is4(h, 8, "hevc") ||
                     is4(h, 8, "hevx") || is4(h, 8, "mif1") || is4(h, 8, "msf1") ||
                     is4(h, 8, "heim") || is4(h, 8, "heis"))
                kind = FMT_HEIF;
            else
                kind = FMT_VIDEO;
        end
        else if (html)
            kind = FMT_HTML;
        else
            kind = FMT_UNKNOWN;

        known = 1'b0;
        wd    = '0;
        hd    = '0;
        w32   = '0;
        h32   = '0;
        v     = '0;
        case (kind)
            FMT_PNG:
            begin
                known = n >= CNT_W'(24);
                wd    = clamp(be32(h, 16));
                hd    = clamp(be32(h, 20));
            end
            FMT_GIF:
            begin
                known = n >= CNT_W'(10);
                wd    = DIM_W'({h[7], h[6]});
                hd    = DIM_W'({h[9], h[8]});
            end
            FMT_BMP:
            begin
                known = n >= CNT_W'(26);
                if (le32(h, 14) == 32'd12)
                begin
                    wd = DIM_W'({h[19], h[18]});
                    hd = DIM_W'({h[21], h[20]});
                end
                else
                begin
                    wd = clamp(le32(h, 18));
                    v  = le32(h, 22);
                    // The most negative height has no positive twin and saturates.
                    if (v == 32'h80000000)
                        hd = DIM_MAX;
                    else if (v[31])
                    begin
                        h32 = 32'd0 - v;
                        hd  = h32[30:0];
                    end
                    else
                        hd = v[30:0];
                end
            end
            FMT_WEBP:
            begin
                if (n >= CNT_W'(30))
                begin
                    if (is4(h, 12, "VP8 "))
                    begin
                        known = 1'b1;
                        wd    = DIM_W'({h[27][5:0], h[26]});
                        hd    = DIM_W'({h[29][5:0], h[28]});
                    end
                    else if (is4(h, 12, "VP8L"))
                    begin
                        known = 1'b1;
                        v     = le32(h, 21);
                        wd    = DIM_W'(v[13:0]) + 1'b1;
                        hd    = DIM_W'(v[27:14]) + 1'b1;
                    end
                    else if (is4(h, 12, "VP8X"))
                    begin
                        known = 1'b1;
                        w32   = {8'd0, h[26], h[25], h[24]} + 32'd1;
                        wd    = w32[30:0];
                        v     = {8'd0, h[29], h[28], h[27]} + 32'd1;
                        hd    = v[30:0];
                    end
                end
            end
            default:
            begin
                known = 1'b0;
            end
        endcase

        result.kind  = kind;
        result.known = known;
        if (!known)
        begin
            result.width  = '0;
            result.height = '0;
            result.status = EDGE_NOT_CHECKED;
        end
        else
        begin
            result.width  = wd;
            result.height = hd;
            if (wd == '0 || hd == '0)
                result.status = EDGE_EMPTY;
            else if (wd > max_edge || hd > max_edge)
                result.status = EDGE_TOO_LARGE;
            else
                result.status = EDGE_OK;
        end
    end

endmodule

// ===== sim/image_format_sniffer_checker.sv =====
// Checker for the image format sniffer: predicts each result and compares it.
`timescale 1ns / 100ps
module image_format_sniffer_checker
    import ifs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    output int unsigned fail_count,
    output int unsigned results_pending,
    output int unsigned results_seen
);

    localparam int unsigned HEAD_N  = 32;
    localparam int unsigned PROBE_N = 16;
    localparam logic [2:0] ADDR_MAX_EDGE = 3'd0;

    byte_t       head_mem [HEAD_N];
    int unsigned head_cnt;
    phase_t      probe_ph;
    byte_t       probe_mem [PROBE_N];
    int unsigned probe_cnt;
    dim_t        edge_limit;
    result_t     sniff_q [$];

    function automatic bit is_blank(byte_t c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic void probe_take(byte_t c);
        if (probe_ph == PH_SKIP)
        begin
            if (is_blank(c))
                return;
            probe_ph = PH_COLLECT;
        end
        if (probe_ph == PH_COLLECT)
        begin
            if (probe_cnt < PROBE_N)
            begin
                probe_mem[probe_cnt] = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
                probe_cnt++;
            end
            if (probe_cnt >= PROBE_N)
                probe_ph = PH_FULL;
        end
    endfunction

    // The signature is given with its first byte in the most significant position.
    function automatic bit head_match(int unsigned off, logic [63:0] sig, int unsigned len);
        if (head_cnt < off + len)
            return 1'b0;
        for (int unsigned i = 0; i < len; i++)
            if (head_mem[off + i] != sig[8 * (len - 1 - i) +: 8])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit probe_match(logic [71:0] sig, int unsigned len);
        if (probe_cnt < len)
            return 1'b0;
        for (int unsigned i = 0; i < len; i++)
            if (probe_mem[i] != sig[8 * (len - 1 - i) +: 8])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [31:0] head_le(int unsigned p, int unsigned n);
        logic [31:0] v;
        v = '0;
        for (int unsigned i = 0; i < n; i++)
            v[8 * i +: 8] = head_mem[p + i];
        return v;
    endfunction

    function automatic dim_t clamp31(logic [31:0] v);
        return v[31] ? DIM_MAX : v[30:0];
    endfunction

    function automatic fmt_t sniff_format();
        if (head_cnt < 4)
            return FMT_UNKNOWN;
        if (head_match(0, 24'hFFD8FF, 3))
            return FMT_JPEG;
        if (head_match(0, 64'h89504E470D0A1A0A, 8))
            return FMT_PNG;
        if (head_match(0, "GIF87a", 6) || head_match(0, "GIF89a", 6))
            return FMT_GIF;
        if (head_match(0, "BM", 2) && head_cnt > 14)
            return FMT_BMP;
        if (head_match(0, 32'h49492A00, 4) || head_match(0, 32'h4D4D002A, 4))
            return FMT_TIFF;
        if (head_match(0, "RIFF", 4) && head_cnt >= 12)
        begin
            if (head_match(8, "WEBP", 4))
                return FMT_WEBP;
            if (head_match(8, "AVI ", 4))
                return FMT_VIDEO;
        end
        if (head_match(0, 32'h1A45DFA3, 4) || head_match(0, "FLV", 3) ||
            head_match(0, 32'h000001BA, 4) || head_match(0, "OggS", 4) ||
            head_match(0, 32'h3026B275, 4))
            return FMT_VIDEO;
        if (head_cnt >= 12 && head_match(4, "ftyp", 4))
        begin
            if (head_match(8, "avif", 4) || head_match(8, "avis", 4))
                return FMT_AVIF;
            if (head_match(8, "heic", 4) || head_match(8, "heix", 4) ||
                head_match(8, "hevc", 4) || head_match(8, "hevx", 4) ||
                head_match(8, "mif1", 4) || head_match(8, "msf1", 4) ||
                head_match(8, "heim", 4) || head_match(8, "heis", 4))
                return FMT_HEIF;
            return FMT_VIDEO;
        end
        if (probe_match("<!doctype", 9) || probe_match("<html", 5) ||
            probe_match("<?xml", 5) || probe_match("<head", 5))
            return FMT_HTML;
        return FMT_UNKNOWN;
    endfunction

    // Returns 1 when the header carries dimensions, with width and height filled in.
    function automatic bit dims_from_header(fmt_t kind, output dim_t w, output dim_t h);
        logic [31:0] v;
        w = '0;
        h = '0;
        case (kind)
            FMT_PNG:
            begin
                if (head_cnt < 24)
                    return 1'b0;
                w = clamp31({head_mem[16], head_mem[17], head_mem[18], head_mem[19]});
                h = clamp31({head_mem[20], head_mem[21], head_mem[22], head_mem[23]});
                return 1'b1;
            end
            FMT_GIF:
            begin
                if (head_cnt < 10)
                    return 1'b0;
                w = dim_t'(head_le(6, 2));
                h = dim_t'(head_le(8, 2));
                return 1'b1;
            end
            FMT_BMP:
            begin
                if (head_cnt < 26)
                    return 1'b0;
                if (head_le(14, 4) == 32'd12)
                begin
                    w = dim_t'(head_le(18, 2));
                    h = dim_t'(head_le(20, 2));
                    return 1'b1;
                end
                w = clamp31(head_le(18, 4));
                v = head_le(22, 4);
                // A top-down bitmap stores its height negated.
                if (v == 32'h8000_0000)
                    h = DIM_MAX;
                else if (v[31])
                    h = dim_t'(-v);
                else
                    h = v[30:0];
                return 1'b1;
            end
            FMT_WEBP:
            begin
                if (head_cnt < 30)
                    return 1'b0;
                if (head_match(12, "VP8 ", 4))
                begin
                    w = dim_t'(head_le(26, 2) & 32'h3FFF);
                    h = dim_t'(head_le(28, 2) & 32'h3FFF);
                    return 1'b1;
                end
                if (head_match(12, "VP8L", 4))
                begin
                    v = head_le(21, 4);
                    w = v[13:0] + 31'd1;
                    h = v[27:14] + 31'd1;
                    return 1'b1;
                end
                if (head_match(12, "VP8X", 4))
                begin
                    w = dim_t'(head_le(24, 3) + 32'd1);
                    h = dim_t'(head_le(27, 3) + 32'd1);
                    return 1'b1;
                end
                return 1'b0;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic void clear_file();
        foreach (head_mem[i])
            head_mem[i] = '0;
        foreach (probe_mem[i])
            probe_mem[i] = '0;
        head_cnt = 0;
        probe_ph = PH_MARK;
        probe_cnt = 0;
    endfunction

    function automatic void take_byte(byte_t c, bit last);
        int unsigned idx;
        result_t r;
        dim_t w;
        dim_t h;
        idx = head_cnt;
        if (idx < HEAD_N)
        begin
            head_mem[idx] = c;
            head_cnt = idx + 1;
        end
        if (probe_ph == PH_MARK)
        begin
            // The probe starts at the third byte, once a byte-order mark can be ruled out.
            if (idx >= 2)
            begin
                probe_ph = PH_SKIP;
                if (!(head_mem[0] == 8'hEF && head_mem[1] == 8'hBB && head_mem[2] == 8'hBF))
                begin
                    probe_take(head_mem[0]);
                    probe_take(head_mem[1]);
                    probe_take(head_mem[2]);
                end
            end
        end
        else
            probe_take(c);
        if (!last)
            return;
        r.kind = sniff_format();
        r.known = dims_from_header(r.kind, w, h);
        r.width = w;
        r.height = h;
        if (!r.known)
            r.status = EDGE_NOT_CHECKED;
        else if (w == 0 || h == 0)
            r.status = EDGE_EMPTY;
        else if (w > edge_limit || h > edge_limit)
            r.status = EDGE_TOO_LARGE;
        else
            r.status = EDGE_OK;
        sniff_q = {sniff_q, r};
        clear_file();
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            clear_file();
            edge_limit = 31'd16384;
            sniff_q.delete();
            fail_count = 0;
            results_seen = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_MAX_EDGE)
                edge_limit = pwdata[30:0];
            if (s_tvalid && s_tready)
                take_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (sniff_q.size() == 0)
                begin
                    $error("unexpected result word %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = sniff_q.pop_front();
                    if (m_tdata[3:0] != want.kind)
                    begin
                        $error("format_kind expected %0d got %0d", want.kind, m_tdata[3:0]);
                        fail_count++;
                    end
                    if (m_tdata[34:4] != want.width)
                    begin
                        $error("image_width expected %0d got %0d", want.width, m_tdata[34:4]);
                        fail_count++;
                    end
                    if (m_tdata[65:35] != want.height)
                    begin
                        $error("image_height expected %0d got %0d", want.height,
                               m_tdata[65:35]);
                        fail_count++;
                    end
                    if (m_tdata[66] != want.known)
                    begin
                        $error("dims_known expected %0d got %0d", want.known, m_tdata[66]);
                        fail_count++;
                    end
                    if (m_tdata[68:67] != want.status)
                    begin
                        $error("edge_status expected %0d got %0d", want.status,
                               m_tdata[68:67]);
                        fail_count++;
                    end
                end
            end
        end
        results_pending = sniff_q.size();
    end

endmodule

// ===== sim/image_format_sniffer_test.sv =====
// Testbench top for the image format sniffer: stimulus, pacing and verdict.
`timescale 1ns / 100ps
module image_format_sniffer_test
    import ifs_pkg::*;
();

    // File templates. Each one builds a header of its kind with random content.
    localparam int T_PNG   = 0;
    localparam int T_GIF   = 1;
    localparam int T_BMP   = 2;
    localparam int T_WEBP  = 3;
    localparam int T_AVI   = 4;
    localparam int T_FTYP  = 5;
    localparam int T_VIDEO = 6;
    localparam int T_JPEG  = 7;
    localparam int T_TIFF  = 8;
    localparam int T_HTML  = 9;
    localparam int T_NOISE = 10;
    localparam int T_COUNT = 11;

    localparam logic [2:0] ADDR_MAX_EDGE = 3'd0;
    localparam int IMG_MAX     = 64;
    localparam int WATCH_LIMIT = 3000;
    localparam int LONG_HOLD   = 400;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [7:0] data_byte
    logic        s_tlast;     // last_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;     // [3:0] format_kind, [34:4] image_width, [65:35] image_height,
                              // [66] dims_known, [68:67] edge_status, [71:69] zero

    int unsigned fail_count;
    int unsigned results_pending;
    int unsigned results_seen;

    byte_t       img [IMG_MAX];
    int unsigned bytes_sent;
    int unsigned files_sent;
    logic [31:0] cur_edge;
    bit          calm_pacing;   // when set, neither side inserts gaps
    bit          hold_req;      // asks the receiver for one long hold-off
    int unsigned quiet_cycles;

    image_format_sniffer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    image_format_sniffer_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .results_pending (results_pending),
        .results_seen    (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Most gaps are short; a few are long enough to span a whole file header.
    function automatic int unsigned gap_len();
        int unsigned r;
        if (calm_pacing)
            return 0;
        r = $urandom_range(0, 15);
        if (r < 10)
            return 0;
        if (r < 15)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Dimension values that hit zero, one, the edge limit and the clamp point.
    function automatic logic [31:0] pick_dim();
        case ($urandom_range(0, 6))
            0: return 32'd0;
            1: return 32'd1;
            2: return $urandom_range(2, 20000);
            3: return cur_edge + $urandom_range(0, 2) - 1;
            4: return 32'h8000_0000 | $urandom;
            5: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic void put_str(int at, string s);
        for (int i = 0; i < s.len(); i++)
            img[at + i] = s[i];
    endfunction

    function automatic void put_le(int at, logic [31:0] v, int n);
        for (int i = 0; i < n; i++)
            img[at + i] = v[8 * i +: 8];
    endfunction

    function automatic void put_be(int at, logic [31:0] v, int n);
        for (int i = 0; i < n; i++)
            img[at + i] = v[8 * (n - 1 - i) +: 8];
    endfunction

    // Fills img with one file of the given template and variant; returns its full length.
    function automatic int build_file(int tpl, int variant);
        string kw;
        int pos;
        int full;
        foreach (img[i])
            img[i] = byte_t'($urandom);
        full = 30 + $urandom_range(0, 2);
        case (tpl)
            T_PNG:
            begin
                put_be(0, 32'h8950_4E47, 4);
                put_be(4, 32'h0D0A_1A0A, 4);
                put_be(16, pick_dim(), 4);
                put_be(20, pick_dim(), 4);
            end
            T_GIF:
            begin
                put_str(0, variant % 2 ? "GIF89a" : "GIF87a");
                put_le(6, pick_dim(), 2);
                put_le(8, pick_dim(), 2);
                full = $urandom_range(10, 20);
            end
            T_BMP:
            begin
                put_str(0, "BM");
                case (variant % 4)
                    0:
                    begin
                        put_le(14, 32'd12, 4);
                        put_le(18, pick_dim(), 2);
                        put_le(20, pick_dim(), 2);
                    end
                    1:
                    begin
                        put_le(14, 32'd40, 4);
                        put_le(18, pick_dim(), 4);
                        put_le(22, -pick_dim(), 4);
                    end
                    2:
                    begin
                        put_le(14, $urandom, 4);
                        put_le(18, pick_dim(), 4);
                        put_le(22, 32'h8000_0000, 4);
                    end
                    default:
                    begin
                        put_le(14, 32'd40, 4);
                        put_le(18, pick_dim(), 4);
                        put_le(22, pick_dim(), 4);
                    end
                endcase
            end
            T_WEBP:
            begin
                put_str(0, "RIFF");
                put_str(8, "WEBP");
                case (variant % 4)
                    0: put_str(12, "VP8 ");
                    1: put_str(12, "VP8L");
                    2: put_str(12, "VP8X");
                    default: put_str(12, "VP8Q");
                endcase
                if (variant % 4 == 0)
                begin
                    put_le(26, pick_dim(), 2);
                    put_le(28, pick_dim(), 2);
                end
                else if (variant % 4 == 2)
                begin
                    put_le(24, pick_dim() - 1, 3);
                    put_le(27, pick_dim() - 1, 3);
                end
            end
            T_AVI:
            begin
                put_str(0, "RIFF");
                put_str(8, variant % 2 ? "AVI " : "WAVE");
                full = $urandom_range(12, 20);
            end
            T_FTYP:
            begin
                put_str(4, "ftyp");
                case (variant % 12)
                    0: put_str(8, "avif");
                    1: put_str(8, "avis");
                    2: put_str(8, "heic");
                    3: put_str(8, "heix");
                    4: put_str(8, "hevc");
                    5: put_str(8, "hevx");
                    6: put_str(8, "mif1");
                    7: put_str(8, "msf1");
                    8: put_str(8, "heim");
                    9: put_str(8, "heis");
                    10: put_str(8, "isom");
                    default: put_str(8, "mp42");
                endcase
                full = $urandom_range(12, 16);
            end
            T_VIDEO:
            begin
                case (variant % 5)
                    0: put_be(0, 32'h1A45_DFA3, 4);
                    1: put_str(0, "FLV");
                    2: put_be(0, 32'h0000_01BA, 4);
                    3: put_str(0, "OggS");
                    default: put_be(0, 32'h3026_B275, 4);
                endcase
                full = $urandom_range(4, 16);
            end
            T_JPEG:
            begin
                put_be(0, 32'hFFD8_FF00 | $urandom_range(0, 255), 4);
                full = $urandom_range(4, 16);
            end
            T_TIFF:
            begin
                put_be(0, variant % 2 ? 32'h4D4D_002A : 32'h4949_2A00, 4);
                full = $urandom_range(4, 16);
            end
            T_HTML:
            begin
                pos = 0;
                if (variant % 2)
                begin
                    put_be(0, 32'h00EF_BBBF, 3);
                    pos = 3;
                end
                repeat ($urandom_range(0, 4))
                begin
                    case ($urandom_range(0, 5))
                        0: img[pos] = 8'd9;
                        1: img[pos] = 8'd10;
                        2: img[pos] = 8'd11;
                        3: img[pos] = 8'd12;
                        4: img[pos] = 8'd13;
                        default: img[pos] = 8'd32;
                    endcase
                    pos++;
                end
                case ((variant / 2) % 5)
                    0: kw = "<!doctype";
                    1: kw = "<html";
                    2: kw = "<?xml";
                    3: kw = "<head";
                    default: kw = "<!docty";
                endcase
                // Mixed case checks the lowercasing of the probe.
                for (int i = 0; i < kw.len(); i++)
                    img[pos + i] = ($urandom_range(0, 1) && kw[i] >= "a" && kw[i] <= "z") ?
                                   kw[i] - 8'd32 : kw[i];
                full = pos + kw.len() + $urandom_range(0, 4);
            end
            default:
                full = $urandom_range(1, IMG_MAX);
        endcase
        return full;
    endfunction

    // Leaves tvalid high after the last byte when no gap follows; the next
    // file or the following drain takes it over.
    task automatic send_file(int len);
        int unsigned g;
        for (int i = 0; i < len; i++)
        begin
            s_tvalid <= 1'b1;
            s_tdata <= img[i];
            s_tlast <= (i == len - 1);
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            bytes_sent++;
            g = gap_len();
            if (g != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (g)
                    @(posedge clk);
            end
        end
        files_sent++;
    endtask

    // Sends one template file, sometimes cut short at a random point.
    task automatic send_template(int tpl, int variant);
        int len;
        len = build_file(tpl, variant);
        if ($urandom_range(0, 7) == 0)
            len = $urandom_range(1, len);
        send_file(len);
    endtask

    // Waits until every expected result has arrived and the pipeline has emptied.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (5)
            @(posedge clk);
    endtask

    task automatic write_max_edge(logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_MAX_EDGE;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cur_edge = value;
    endtask

    // Receiver: runs of readiness and stalls, plus one long hold-off on request.
    initial
    begin
        int unsigned stall;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD)
                    @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                stall = gap_len();
                m_tready <= (stall == 0);
                repeat (stall)
                    @(posedge clk);
            end
        end
    end

    // Watchdog: ends the run when no word moves on either stream for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", WATCH_LIMIT);
            $display("image_format_sniffer_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] edge_plan [4];
        int unsigned phase_files;
        rst_n = 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tlast <= 1'b0;
        hold_req = 1'b0;
        calm_pacing = 1'b1;
        bytes_sent = 0;
        files_sent = 0;
        cur_edge = 32'd16384;
        edge_plan[0] = 32'd1;
        edge_plan[1] = 32'h7FFF_FFFF;
        edge_plan[2] = $urandom_range(2, 70000);
        edge_plan[3] = 32'd16384;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset limit: each template at full length, in every variant
        // for BMP, WEBP, FTYP, video and HTML, then files too short to name a format. Every
        // other template runs without gaps so that files also follow each other back to back.
        for (int tpl = 0; tpl < T_COUNT; tpl++)
        begin
            calm_pacing = (tpl % 2 == 0);
            for (int v = 0; v < ((tpl == T_FTYP) ? 12 : (tpl == T_HTML) ? 10 :
                                 (tpl == T_VIDEO) ? 5 : 4); v += 1)
            begin
                if (v > 0 && !(tpl inside {T_FTYP, T_HTML, T_BMP, T_WEBP, T_VIDEO}))
                    break;
                send_file(build_file(tpl, v));
            end
        end
        calm_pacing = 1'b1;
        for (int n = 1; n <= 3; n++)
        begin
            void'(build_file(T_PNG, 0));
            send_file(n);
        end
        calm_pacing = 1'b0;
        drain();

        // Random part, one limit setting per phase; the sender waits out each drain.
        foreach (edge_plan[p])
        begin
            write_max_edge(edge_plan[p]);
            if (p == 1)
                hold_req = 1'b1;
            phase_files = 0;
            while (phase_files < 2)
            begin
                if ($urandom_range(0, 9) < 8)
                    send_template($urandom_range(0, T_HTML), $urandom_range(0, 11));
                else
                    send_template(T_NOISE, 0);
                phase_files++;
            end
            drain();
        end

        repeat (20)
            @(posedge clk);
        $display("Sent %0d files (%0d bytes) over all format templates and four edge limits;",
                 files_sent, bytes_sent);
        $display("%0d results checked, %0d mismatches.", results_seen, fail_count);
        if (fail_count == 0 && results_pending == 0)
            $display("image_format_sniffer_test OK");
        else
            $display("image_format_sniffer_test NOT OK");
        $finish;
    end

endmodule
